// ===== rtl/hrbp_pkg.sv =====
// Shared types, character constants and match tables for the HTTP response byte parser.
package hrbp_pkg;

    localparam int STATUS_CAPACITY_DEF = 20;
    localparam int COOKIE_CAPACITY_DEF = 32;

    localparam int POS_W      = 6;
    localparam int PROTO_LEN  = 8;
    localparam int OK_LEN     = 15;
    localparam int CK_NAME_LEN = 12;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_START = 2'd1,
        OP_END   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic        msg_valid;
        logic [7:0]  msg_char;
        logic        msg_end;
        logic        response_seen;
        logic        status_ok;
        logic        body_done;
        logic [15:0] index_value;
    } result_t;

    function automatic logic [7:0] ok_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2F;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2E;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h20;
            4'd9:    c = 8'h32;
            4'd10:   c = 8'h30;
            4'd11:   c = 8'h30;
            4'd12:   c = 8'h20;
            4'd13:   c = 8'h4F;
            4'd14:   c = 8'h4B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cookie_name_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h2D;
            4'd4:    c = 8'h43;
            4'd5:    c = 8'h6F;
            4'd6:    c = 8'h6F;
            4'd7:    c = 8'h6B;
            4'd8:    c = 8'h69;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h3A;
            4'd11:   c = 8'h20;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/http_response_byte_parser_unit.sv =====
// Top level of the HTTP response byte parser: input register, parser core, result register.
// A word accepted into the input register moves on to the result register through the core.
// Throughput: one word per cycle unless the output stalls; the parser state forms the loop.
// The cookie store read is registered and lands in the result register stage.
// Reset clears the parser state, the cookie valid bits and both pipeline stages;
// the block accepts words in the first cycle after reset with no clearing pass.
module http_response_byte_parser_unit #(
    parameter int STATUS_CAPACITY = hrbp_pkg::STATUS_CAPACITY_DEF,
    parameter int COOKIE_CAPACITY = hrbp_pkg::COOKIE_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // data_byte[7:0], cookie_position[13:8], zero[15:14]
    input  logic [1:0]  s_tuser,  // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // msg_char[7:0], msg_end[8], response_seen[9],
                                  // status_ok[10], body_done[11], index_value[27:12],
                                  // cookie_char[35:28], zero[39:36]
    output logic        m_tuser   // msg_valid[0]
);

    localparam int AW = $clog2(COOKIE_CAPACITY + 1);

    logic                       s1_valid_reg;
    hrbp_pkg::op_t              s1_op_reg;
    logic [7:0]                 s1_byte_reg;
    logic [hrbp_pkg::POS_W-1:0] s1_pos_reg;
    logic                       m_valid_reg;
    hrbp_pkg::result_t          res_reg;
    hrbp_pkg::result_t          res_next;
    logic                       advance;
    logic                       ck_wr_en;
    logic [AW-1:0]              ck_wr_addr;
    logic [7:0]                 ck_wr_data;
    logic [7:0]                 cookie_char;

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.msg_valid;
    assign m_tdata  = {4'd0, cookie_char, res_reg.index_value, res_reg.body_done,
                       res_reg.status_ok, res_reg.response_seen, res_reg.msg_end,
                       res_reg.msg_char};

    hrbp_core #(
        .STATUS_CAPACITY (STATUS_CAPACITY),
        .COOKIE_CAPACITY (COOKIE_CAPACITY),
        .AW              (AW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (advance),
        .op         (s1_op_reg),
        .data_byte  (s1_byte_reg),
        .result     (res_next),
        .ck_wr_en   (ck_wr_en),
        .ck_wr_addr (ck_wr_addr),
        .ck_wr_data (ck_wr_data)
    );

    hrbp_cookie_mem #(
        .COOKIE_CAPACITY (COOKIE_CAPACITY),
        .DEPTH           (COOKIE_CAPACITY + 1),
        .AW              (AW)
    ) u_cookie_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ck_wr_en),
        .wr_addr (ck_wr_addr),
        .wr_data (ck_wr_data),
        .rd_take (advance),
        .rd_en   (s1_op_reg == hrbp_pkg::OP_READ),
        .rd_pos  (s1_pos_reg),
        .rd_char (cookie_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_op_reg   <= hrbp_pkg::op_t'(s_tuser);
            s1_byte_reg <= s_tdata[7:0];
            s1_pos_reg  <= s_tdata[13:8];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (!res_reg.status_ok || res_reg.response_seen))
        else $error("status_ok reported without response_seen");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(res_reg.msg_valid && res_reg.msg_end))
        else $error("message character and message end in the same word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both pipeline stages are held");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_valid_reg)
        else $error("advanced word did not reach the result register");
`endif

endmodule

// ===== rtl/hrbp_cookie_mem.sv =====
// Cookie value store with per-entry valid bits and a registered read port.
module hrbp_cookie_mem #(
    parameter int COOKIE_CAPACITY = hrbp_pkg::COOKIE_CAPACITY_DEF,
    parameter int DEPTH = COOKIE_CAPACITY + 1,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [7:0]                wr_data,
    input  logic                      rd_take,
    input  logic                      rd_en,
    input  logic [hrbp_pkg::POS_W-1:0] rd_pos,
    output logic [7:0]                rd_char
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [7:0]       char_reg;
    logic [AW-1:0]    rd_addr;
    logic             rd_hit;

    assign rd_addr = rd_pos[AW-1:0];
    assign rd_hit  = rd_en && (rd_pos <= hrbp_pkg::POS_W'(COOKIE_CAPACITY))
                     && valid_reg[rd_addr];
    assign rd_char = char_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (AW'(i) == wr_addr)
                begin
                    valid_next[i] = 1'b1;
                end
                else if (AW'(i) == wr_addr + AW'(1))
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_take)
        begin
            char_reg <= rd_hit ? mem[rd_addr] : 8'd0;
        end
    end

endmodule

// ===== rtl/hrbp_core.sv =====
// Parser state registers and the next-state and result logic for one word.
module hrbp_core #(
    parameter int STATUS_CAPACITY = hrbp_pkg::STATUS_CAPACITY_DEF,
    parameter int COOKIE_CAPACITY = hrbp_pkg::COOKIE_CAPACITY_DEF,
    parameter int AW = $clog2(COOKIE_CAPACITY + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  hrbp_pkg::op_t     op,
    input  logic [7:0]        data_byte,
    output hrbp_pkg::result_t result,
    output logic              ck_wr_en,
    output logic [AW-1:0]     ck_wr_addr,
    output logic [7:0]        ck_wr_data
);

    localparam int LW      = $clog2(STATUS_CAPACITY + 1);
    localparam int CK_ERR  = hrbp_pkg::CK_NAME_LEN + COOKIE_CAPACITY;
    localparam int CK_DONE = CK_ERR + 1;
    localparam int SW      = $clog2(CK_DONE + 1);

    typedef enum logic [2:0] {
        SEC_LINE1  = 3'd0,
        SEC_HDR0   = 3'd1,
        SEC_HDR1   = 3'd2,
        SEC_HDRANY = 3'd3,
        SEC_BODY   = 3'd4
    } section_t;

    typedef enum logic [2:0] {
        BD_TWO     = 3'd0,
        BD_COMMA1  = 3'd1,
        BD_MSG     = 3'd2,
        BD_WAITIDX = 3'd3,
        BD_IDX     = 3'd4,
        BD_DONE    = 3'd5,
        BD_ERR     = 3'd6
    } body_t;

    section_t      section_reg, section_next;
    logic [LW-1:0] len_reg, len_next;
    logic          p8_reg, p8_next;
    logic          p15_reg, p15_next;
    logic [SW-1:0] ck_step_reg, ck_step_next;
    body_t         body_reg, body_next;
    logic [15:0]   index_reg, index_next;

    logic          eoln;
    logic          hdr;
    logic          seen;
    logic          ok;
    logic          is_digit;
    logic          char_match;
    logic [SW-1:0] ck_off;
    logic [15:0]   index_step;

    assign eoln       = (data_byte == hrbp_pkg::CH_CR) || (data_byte == hrbp_pkg::CH_LF);
    assign is_digit   = (data_byte >= hrbp_pkg::CH_ZERO) && (data_byte <= hrbp_pkg::CH_NINE);
    assign char_match = (data_byte == hrbp_pkg::ok_char(len_reg[3:0]));
    assign ck_off     = ck_step_reg - SW'(hrbp_pkg::CK_NAME_LEN);
    assign index_step = {index_reg[12:0], 3'b000} + {index_reg[14:0], 1'b0}
                        + {8'd0, data_byte - hrbp_pkg::CH_ZERO};
    assign seen       = (section_reg != SEC_LINE1) && p8_reg
                        && (len_reg >= LW'(hrbp_pkg::PROTO_LEN));
    assign ok         = seen && p15_reg && (len_reg == LW'(hrbp_pkg::OK_LEN));

    always_comb
    begin
        section_next = section_reg;
        len_next     = len_reg;
        p8_next      = p8_reg;
        p15_next     = p15_reg;
        ck_step_next = ck_step_reg;
        body_next    = body_reg;
        index_next   = index_reg;
        result       = '0;
        hdr          = 1'b0;
        ck_wr_en     = 1'b0;
        ck_wr_addr   = ck_off[AW-1:0];
        ck_wr_data   = data_byte;

        if (take)
        begin
            case (op)
                hrbp_pkg::OP_DATA:
                begin
                    case (section_reg)
                        SEC_LINE1:
                        begin
                            if (data_byte == hrbp_pkg::CH_LF)
                            begin
                                section_next = SEC_HDR0;
                            end
                            else if (data_byte != hrbp_pkg::CH_CR
                                     && len_reg < LW'(STATUS_CAPACITY))
                            begin
                                if (len_reg < LW'(hrbp_pkg::PROTO_LEN))
                                begin
                                    p8_next = p8_reg && char_match;
                                end
                                if (len_reg < LW'(hrbp_pkg::OK_LEN))
                                begin
                                    p15_next = p15_reg && char_match;
                                end
                                len_next = len_reg + LW'(1);
                            end
                        end
                        SEC_HDR0:
                        begin
                            hdr = 1'b1;
                            if (data_byte == hrbp_pkg::CH_CR)
                            begin
                                section_next = SEC_HDR1;
                            end
                            else if (data_byte == hrbp_pkg::CH_LF)
                            begin
                                section_next = SEC_BODY;
                            end
                            else
                            begin
                                section_next = SEC_HDRANY;
                            end
                        end
                        SEC_HDR1:
                        begin
                            hdr = 1'b1;
                            section_next = (data_byte == hrbp_pkg::CH_LF) ? SEC_BODY : SEC_HDR0;
                        end
                        SEC_HDRANY:
                        begin
                            hdr = 1'b1;
                            if (data_byte == hrbp_pkg::CH_LF)
                            begin
                                section_next = SEC_HDR0;
                            end
                        end
                        SEC_BODY:
                        begin
                            case (body_reg)
                                BD_TWO:
                                begin
                                    body_next = (data_byte == hrbp_pkg::CH_TWO) ? BD_COMMA1 : BD_ERR;
                                end
                                BD_COMMA1:
                                begin
                                    body_next = (data_byte == hrbp_pkg::CH_COMMA) ? BD_MSG : BD_ERR;
                                end
                                BD_MSG:
                                begin
                                    if (data_byte == hrbp_pkg::CH_COMMA)
                                    begin
                                        result.msg_end = 1'b1;
                                        body_next = BD_WAITIDX;
                                    end
                                    else
                                    begin
                                        result.msg_valid = 1'b1;
                                        result.msg_char  = data_byte;
                                    end
                                end
                                BD_WAITIDX:
                                begin
                                    if (data_byte == hrbp_pkg::CH_COMMA)
                                    begin
                                        body_next  = BD_IDX;
                                        index_next = 16'd0;
                                    end
                                end
                                BD_IDX:
                                begin
                                    if (eoln)
                                    begin
                                        body_next = BD_DONE;
                                    end
                                    else if (is_digit)
                                    begin
                                        index_next = index_step;
                                    end
                                    else
                                    begin
                                        body_next = BD_ERR;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                hrbp_pkg::OP_START:
                begin
                    section_next = SEC_LINE1;
                    len_next     = '0;
                    p8_next      = 1'b1;
                    p15_next     = 1'b1;
                    ck_step_next = '0;
                    body_next    = BD_TWO;
                end
                hrbp_pkg::OP_END:
                begin
                    result.response_seen = seen;
                    result.status_ok     = ok;
                    if (ok && body_reg != BD_DONE)
                    begin
                        index_next = 16'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (hdr)
        begin
            if (ck_step_reg < SW'(hrbp_pkg::CK_NAME_LEN))
            begin
                if (eoln)
                begin
                    ck_step_next = '0;
                end
                else if (data_byte == hrbp_pkg::cookie_name_char(ck_step_reg[3:0]))
                begin
                    ck_step_next = ck_step_reg + SW'(1);
                end
                else
                begin
                    ck_step_next = SW'(CK_ERR);
                end
            end
            else if (ck_step_reg < SW'(CK_ERR))
            begin
                if (eoln)
                begin
                    ck_step_next = SW'(CK_DONE);
                end
                else
                begin
                    ck_wr_en     = 1'b1;
                    ck_step_next = ck_step_reg + SW'(1);
                end
            end
            else if (ck_step_reg == SW'(CK_ERR))
            begin
                if (eoln)
                begin
                    ck_step_next = '0;
                end
            end
        end

        result.body_done   = (body_next == BD_DONE);
        result.index_value = index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg <= SEC_LINE1;
            len_reg     <= '0;
            p8_reg      <= 1'b1;
            p15_reg     <= 1'b1;
            ck_step_reg <= '0;
            body_reg    <= BD_TWO;
            index_reg   <= 16'd0;
        end
        else
        begin
            section_reg <= section_next;
            len_reg     <= len_next;
            p8_reg      <= p8_next;
            p15_reg     <= p15_next;
            ck_step_reg <= ck_step_next;
            body_reg    <= body_next;
            index_reg   <= index_next;
        end
    end

endmodule

// ===== bench/http_response_byte_parser_unit_tb.sv =====
// Self-checking testbench for the HTTP response byte parser with random stream traffic.
module http_response_byte_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATUS_CAP = hrbp_pkg::STATUS_CAPACITY_DEF;
    localparam int COOKIE_CAP = hrbp_pkg::COOKIE_CAPACITY_DEF;
    localparam int CK_ERR     = hrbp_pkg::CK_NAME_LEN + COOKIE_CAP;
    localparam int CK_DONE    = CK_ERR + 1;
    localparam logic [8*hrbp_pkg::OK_LEN-1:0]      OK_LINE     = "HTTP/1.1 200 OK";
    localparam logic [8*hrbp_pkg::CK_NAME_LEN-1:0] COOKIE_NAME = "Set-Cookie: ";

    typedef enum logic [2:0] {
        SEC_STATUS,
        SEC_LINE_START,
        SEC_CR_SEEN,
        SEC_HEADER,
        SEC_BODY
    } section_t;

    typedef enum logic [2:0] {
        BODY_TWO,
        BODY_COMMA,
        BODY_MSG,
        BODY_SKIP,
        BODY_INDEX,
        BODY_DONE,
        BODY_ERR
    } body_step_t;

    typedef struct packed {
        logic        msg_valid;
        logic [7:0]  msg_char;
        logic        msg_end;
        logic        response_seen;
        logic        status_ok;
        logic        body_done;
        logic [15:0] index_value;
        logic [7:0]  cookie_char;
    } parsed_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [1:0]  s_tuser = hrbp_pkg::OP_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    section_t     parse_section;
    int           status_len;
    logic [7:0]   status_bytes [STATUS_CAP];
    int           cookie_step;
    logic [7:0]   cookie_bytes [COOKIE_CAP + 1];
    body_step_t   body_step;
    logic [15:0]  msg_index;

    parsed_word_t expected_words [$];
    int           words_sent = 0;
    int           mismatches = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    int           hold_cycles_req = 0;
    int           stall_left = 0;

    http_response_byte_parser_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit status_prefix_match(input int n);
        if (status_len < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (status_bytes[i] != OK_LINE[8*(hrbp_pkg::OK_LEN-1-i) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void track_header(input logic [7:0] b);
        bit eol;
        eol = (b == hrbp_pkg::CH_CR) || (b == hrbp_pkg::CH_LF);
        if (cookie_step < hrbp_pkg::CK_NAME_LEN)
        begin
            if (eol)
                cookie_step = 0;
            else if (b == COOKIE_NAME[8*(hrbp_pkg::CK_NAME_LEN-1-cookie_step) +: 8])
                cookie_step++;
            else
                cookie_step = CK_ERR;
        end
        else if (cookie_step < CK_ERR)
        begin
            if (eol)
                cookie_step = CK_DONE;
            else
            begin
                cookie_bytes[cookie_step - hrbp_pkg::CK_NAME_LEN] = b;
                cookie_bytes[cookie_step - hrbp_pkg::CK_NAME_LEN + 1] = 8'h00;
                cookie_step++;
            end
        end
        else if (cookie_step == CK_ERR && eol)
            cookie_step = 0;
    endfunction

    function automatic parsed_word_t parse_word(input hrbp_pkg::op_t op, input logic [7:0] b,
                                                input logic [5:0] pos);
        parsed_word_t r;
        r = '0;
        case (op)
            hrbp_pkg::OP_DATA:
                case (parse_section)
                    SEC_STATUS:
                        if (b == hrbp_pkg::CH_LF)
                            parse_section = SEC_LINE_START;
                        else if (b != hrbp_pkg::CH_CR && status_len < STATUS_CAP)
                        begin
                            status_bytes[status_len] = b;
                            status_len++;
                        end
                    SEC_LINE_START:
                    begin
                        if (b == hrbp_pkg::CH_CR)
                            parse_section = SEC_CR_SEEN;
                        else if (b == hrbp_pkg::CH_LF)
                            parse_section = SEC_BODY;
                        else
                            parse_section = SEC_HEADER;
                        track_header(b);
                    end
                    SEC_CR_SEEN:
                    begin
                        parse_section = (b == hrbp_pkg::CH_LF) ? SEC_BODY : SEC_LINE_START;
                        track_header(b);
                    end
                    SEC_HEADER:
                    begin
                        if (b == hrbp_pkg::CH_LF)
                            parse_section = SEC_LINE_START;
                        track_header(b);
                    end
                    default:
                        case (body_step)
                            BODY_TWO:
                                body_step = (b == hrbp_pkg::CH_TWO) ? BODY_COMMA : BODY_ERR;
                            BODY_COMMA:
                                body_step = (b == hrbp_pkg::CH_COMMA) ? BODY_MSG : BODY_ERR;
                            BODY_MSG:
                                if (b == hrbp_pkg::CH_COMMA)
                                begin
                                    r.msg_end = 1'b1;
                                    body_step = BODY_SKIP;
                                end
                                else
                                begin
                                    r.msg_valid = 1'b1;
                                    r.msg_char = b;
                                end
                            BODY_SKIP:
                                if (b == hrbp_pkg::CH_COMMA)
                                begin
                                    body_step = BODY_INDEX;
                                    msg_index = 16'h0000;
                                end
                            BODY_INDEX:
                                if (b == hrbp_pkg::CH_CR || b == hrbp_pkg::CH_LF)
                                    body_step = BODY_DONE;
                                else if (b >= hrbp_pkg::CH_ZERO && b <= hrbp_pkg::CH_NINE)
                                    msg_index = 16'(msg_index * 10 + (b - hrbp_pkg::CH_ZERO));
                                else
                                    body_step = BODY_ERR;
                            default:
                                ;
                        endcase
                endcase
            hrbp_pkg::OP_START:
            begin
                parse_section = SEC_STATUS;
                status_len = 0;
                cookie_step = 0;
                body_step = BODY_TWO;
            end
            hrbp_pkg::OP_END:
            begin
                r.response_seen = (parse_section != SEC_STATUS)
                                  && status_prefix_match(hrbp_pkg::PROTO_LEN);
                r.status_ok = r.response_seen && status_len == hrbp_pkg::OK_LEN
                              && status_prefix_match(hrbp_pkg::OK_LEN);
                if (r.status_ok && body_step != BODY_DONE)
                    msg_index = 16'h0000;
            end
            default:
                r.cookie_char = (pos <= COOKIE_CAP) ? cookie_bytes[pos] : 8'h00;
        endcase
        r.body_done = (body_step == BODY_DONE);
        r.index_value = msg_index;
        return r;
    endfunction

    task automatic send_word(input hrbp_pkg::op_t op, input logic [7:0] b,
                             input logic [5:0] pos);
        bit took;
        while (tx_idle_on && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, pos, b};
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        expected_words.push_back(parse_word(op, b, pos));
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(hrbp_pkg::OP_DATA, b, 6'($urandom_range(63)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_char(input bit no_comma, input bit no_eol);
        logic [7:0] c;
        do
        begin
            c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
        end
        while ((no_comma && c == hrbp_pkg::CH_COMMA)
               || (no_eol && (c == hrbp_pkg::CH_CR || c == hrbp_pkg::CH_LF)));
        return c;
    endfunction

    task automatic send_line_end();
        if ($urandom_range(1))
            send_byte(hrbp_pkg::CH_CR);
        send_byte(hrbp_pkg::CH_LF);
    endtask

    task automatic send_response();
        int n;
        int len;
        if ($urandom_range(9) != 0)
            send_word(hrbp_pkg::OP_START, 8'($urandom_range(255)), 6'($urandom_range(63)));
        case ($urandom_range(6))
            0, 1: send_text("HTTP/1.1 200 OK");
            2:    send_text("HTTP/1.1 404 Not Found Here");
            3:    send_text("HTTP/1.1 200 OKAY");
            4:    send_text("HTTP/1.0 200 OK");
            5:    send_text("HTTP/1.1");
            default:
            begin
                len = $urandom_range(24);
                for (int i = 0; i < len; i++)
                    send_byte(($urandom_range(9) == 0) ? hrbp_pkg::CH_CR
                                                       : pick_char(1'b0, 1'b1));
            end
        endcase
        if ($urandom_range(9) != 0)
        begin
            send_line_end();
            n = $urandom_range(3);
            for (int h = 0; h < n; h++)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        send_text("Set-Cookie: ");
                        len = $urandom_range(40);
                        for (int i = 0; i < len; i++)
                            send_byte(pick_char(1'b0, 1'b1));
                    end
                    1: send_text("Content-Length: 12");
                    2: send_text("Set-Cookie= x");
                    default:
                    begin
                        len = $urandom_range(10, 1);
                        for (int i = 0; i < len; i++)
                            send_byte(pick_char(1'b0, 1'b1));
                    end
                endcase
                send_line_end();
            end
            case ($urandom_range(9))
                0: send_text("\rX\n");
                1, 2: send_byte(hrbp_pkg::CH_LF);
                default: send_text("\r\n");
            endcase
            if ($urandom_range(4) != 0)
            begin
                send_byte(($urandom_range(9) == 0) ? pick_char(1'b0, 1'b0) : hrbp_pkg::CH_TWO);
                send_byte(($urandom_range(9) == 0) ? pick_char(1'b0, 1'b0)
                                                   : hrbp_pkg::CH_COMMA);
                len = $urandom_range(8);
                for (int i = 0; i < len; i++)
                    send_byte(pick_char(1'b1, 1'b0));
                send_byte(hrbp_pkg::CH_COMMA);
                len = $urandom_range(5);
                for (int i = 0; i < len; i++)
                    send_byte(pick_char(1'b1, 1'b0));
                send_byte(hrbp_pkg::CH_COMMA);
                len = $urandom_range(7, 1);
                for (int i = 0; i < len; i++)
                    send_byte(8'(hrbp_pkg::CH_ZERO + $urandom_range(9)));
                if ($urandom_range(9) == 0)
                    send_byte(pick_char(1'b0, 1'b1));
                else
                    send_byte($urandom_range(1) ? hrbp_pkg::CH_CR : hrbp_pkg::CH_LF);
                len = $urandom_range(2);
                for (int i = 0; i < len; i++)
                    send_byte(pick_char(1'b0, 1'b0));
            end
        end
        if ($urandom_range(19) != 0)
            send_word(hrbp_pkg::OP_END, 8'($urandom_range(255)), 6'($urandom_range(63)));
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
            send_word(hrbp_pkg::OP_READ, 8'($urandom_range(255)),
                      6'(($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(33)));
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_cookie_reads();
        send_word(hrbp_pkg::OP_READ, 8'h00, 6'd0);
        send_word(hrbp_pkg::OP_READ, 8'hFF, 6'd32);
        send_word(hrbp_pkg::OP_READ, 8'h00, 6'd33);
        send_word(hrbp_pkg::OP_READ, 8'hFF, 6'd63);
        send_word(hrbp_pkg::OP_END, 8'h00, 6'd0);
    endtask

    task automatic test_byte_extremes();
        send_word(hrbp_pkg::OP_START, 8'hFF, 6'd63);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(hrbp_pkg::CH_CR);
        send_byte(hrbp_pkg::CH_LF);
    endtask

    task automatic test_short_body();
        send_text("\n2,A,,9\r");
        send_word(hrbp_pkg::OP_END, 8'h00, 6'd0);
        send_word(hrbp_pkg::OP_READ, 8'h00, 6'd0);
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_cycles_req = 80;
        send_word(hrbp_pkg::OP_START, 8'h00, 6'd0);
        send_text("HTTP/1.1 200 OK\r\n\r\n2,stalled,x,4321\n");
        send_word(hrbp_pkg::OP_END, 8'h00, 6'd0);
        send_word(hrbp_pkg::OP_READ, 8'h00, 6'd5);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_responses();
        while (words_sent < 1300)
        begin
            tx_idle_on = !(words_sent > 600 && words_sent < 850);
            rx_idle_on = tx_idle_on;
            send_response();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_noise();
        repeat (150)
            send_word(hrbp_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)),
                      6'($urandom_range(63)));
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles_req != 0)
        begin
            stall_left = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= !(rx_idle_on && $urandom_range(99) < 30);
    end

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        parsed_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result word expected none actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("msg_valid", want.msg_valid, m_tuser);
                compare_field("msg_char", want.msg_char, m_tdata[7:0]);
                compare_field("msg_end", want.msg_end, m_tdata[8]);
                compare_field("response_seen", want.response_seen, m_tdata[9]);
                compare_field("status_ok", want.status_ok, m_tdata[10]);
                compare_field("body_done", want.body_done, m_tdata[11]);
                compare_field("index_value", want.index_value, m_tdata[27:12]);
                compare_field("cookie_char", want.cookie_char, m_tdata[35:28]);
            end
        end
    end

    initial
    begin
        parse_section = SEC_STATUS;
        status_len = 0;
        cookie_step = 0;
        body_step = BODY_TWO;
        msg_index = 16'h0000;
        foreach (status_bytes[i])
            status_bytes[i] = 8'h00;
        foreach (cookie_bytes[i])
            cookie_bytes[i] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_cookie_reads();
        test_byte_extremes();
        test_short_body();
        test_backpressure();
        test_responses();
        test_noise();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("http_response_byte_parser_unit_tb: PASS");
        else
            $display("http_response_byte_parser_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("http_response_byte_parser_unit_tb: FAIL");
        $finish;
    end

endmodule
